// ===== sv/tmte_pkg.sv =====
// ----------------------------------------------------------------------------
// tmte_pkg: shared definitions for the text mode terminal engine
// Field widths, command and register codes, character codes, sequencer
// states and the cell packing function.
// ----------------------------------------------------------------------------
package tmte_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int LINES_W    = 5;
    localparam int CELL_IDX_W = 11;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int CELL_W     = 16;
    localparam int COLOUR_W   = 4;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SCROLL = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

    localparam logic [COLOUR_W-1:0] RESET_FG = 4'd7;
    localparam logic [COLOUR_W-1:0] RESET_BG = 4'd0;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } state_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [COLOUR_W-1:0] fg,
        input logic [COLOUR_W-1:0] bg,
        input logic [CHAR_W-1:0]   ch
    );
        return {bg, fg, ch};
    endfunction

    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BG, RESET_FG, CH_SPACE};

endpackage

// ===== sv/tmte_if.sv =====
// ----------------------------------------------------------------------------
// tmte_req_if / tmte_rsp_if: command and result channels
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface tmte_req_if;
    logic                                valid;
    logic                                ready;
    logic [tmte_pkg::CMD_W-1:0]          command;
    logic [tmte_pkg::CHAR_W-1:0]         char_code;
    logic [tmte_pkg::LINES_W-1:0]        scroll_lines;
    logic [tmte_pkg::CELL_IDX_W-1:0]     cell_index;

    modport source (output valid, command, char_code, scroll_lines, cell_index,
                    input ready);
    modport sink   (input valid, command, char_code, scroll_lines, cell_index,
                    output ready);
endinterface

interface tmte_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [tmte_pkg::COL_OUT_W-1:0]      cursor_col;
    logic [tmte_pkg::ROW_OUT_W-1:0]      cursor_line;
    logic [tmte_pkg::CELL_W-1:0]         read_cell;

    modport source (output valid, cursor_col, cursor_line, read_cell,
                    input ready);
    modport sink   (input valid, cursor_col, cursor_line, read_cell,
                    output ready);
endinterface

// ===== sv/text_mode_terminal_engine.sv =====
// ----------------------------------------------------------------------------
// text_mode_terminal_engine: character screen with cursor
// Screen memory of ROWS x COLUMNS cells under a small sequencer that runs
// put character, clear, scroll up and read cell commands.
// ----------------------------------------------------------------------------
// One command word is taken at a time; the screen memory has one write and
// one read port, and clear, scroll and the line feed at the bottom row step
// through it one cell per cycle. A read cell passes through a read wait state;
// a partial scroll, like a put character that scrolls the screen, copies the
// remaining lines up and then blanks the freed lines, while clear and a scroll
// by ROWS or more only blank the screen. After reset the block blanks the
// screen before ready rises; colour writes are taken at any time. A finished
// result waits in the output register while the next command is already
// accepted.
module text_mode_terminal_engine #(
    parameter int COLUMNS = tmte_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmte_pkg::ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tmte_req_if.sink                         req,
    tmte_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [tmte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmte_pkg::COLOUR_W-1:0]    cfg_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [CNT_W-1:0]  CELL_END  = CNT_W'(CELL_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [COL_W:0]    COL_LIM   = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROW_LIM   = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

    tmte_pkg::state_t state_reg, state_next;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [tmte_pkg::COLOUR_W-1:0] fg_reg, bg_reg;

    tmte_pkg::cmd_t                    cmd_reg, cmd_next;
    logic [tmte_pkg::CHAR_W-1:0]       char_reg, char_next;
    logic [tmte_pkg::LINES_W-1:0]      lines_reg, lines_next;
    logic [tmte_pkg::CELL_IDX_W-1:0]   cell_reg, cell_next;

    logic [CNT_W-1:0] src_reg, src_next;
    logic [CNT_W-1:0] dst_reg, dst_next;
    logic             pend_reg, pend_next;

    logic [tmte_pkg::CELL_W-1:0] read_val_reg, read_val_next;

    logic                               rsp_valid_reg, rsp_valid_next;
    logic [tmte_pkg::COL_OUT_W-1:0]     rsp_col_reg, rsp_col_next;
    logic [tmte_pkg::ROW_OUT_W-1:0]     rsp_row_reg, rsp_row_next;
    logic [tmte_pkg::CELL_W-1:0]        rsp_cell_reg, rsp_cell_next;

    // screen memory
    logic [tmte_pkg::CELL_W-1:0] mem [CELL_COUNT];
    logic [tmte_pkg::CELL_W-1:0] rd_data_reg;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [tmte_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;

    logic [ADDR_W-1:0]           put_addr;
    logic [ADDR_W-1:0]           scroll_off;
    logic                        cell_in_range;
    logic [tmte_pkg::CELL_W-1:0] blank_cell;

    logic [COL_W:0] col_t;
    logic [ROW_W:0] row_t;

    assign put_addr      = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign scroll_off    = ADDR_W'(lines_reg) * COLS_A;
    assign cell_in_range = (32'(cell_reg) < CELL_COUNT);
    assign blank_cell    = tmte_pkg::make_cell(fg_reg, bg_reg, tmte_pkg::CH_SPACE);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.cursor_col  = rsp_col_reg;
    assign rsp.cursor_line = rsp_row_reg;
    assign rsp.read_cell   = rsp_cell_reg;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cmd_next       = cmd_reg;
        char_next      = char_reg;
        lines_next     = lines_reg;
        cell_next      = cell_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        read_val_next  = read_val_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_col_next   = rsp_col_reg;
        rsp_row_next   = rsp_row_reg;
        rsp_cell_next  = rsp_cell_reg;
        mem_we         = 1'b0;
        mem_waddr      = dst_reg[ADDR_W-1:0];
        mem_wdata      = blank_cell;
        mem_re         = 1'b0;
        mem_raddr      = src_reg[ADDR_W-1:0];
        req.ready      = 1'b0;
        col_t          = {1'b0, col_reg};
        row_t          = {1'b0, row_reg};

        case (state_reg)
            tmte_pkg::ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = tmte_pkg::RESET_CELL;
                dst_next  = dst_reg + 1'b1;
                if (dst_reg[ADDR_W-1:0] == LAST_ADDR)
                begin
                    dst_next   = '0;
                    state_next = tmte_pkg::ST_IDLE;
                end
            end

            tmte_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next   = tmte_pkg::cmd_t'(req.command);
                    char_next  = req.char_code;
                    lines_next = req.scroll_lines;
                    cell_next  = req.cell_index;
                    state_next = tmte_pkg::ST_EXEC;
                end
            end

            tmte_pkg::ST_EXEC:
            begin
                read_val_next = '0;
                dst_next      = '0;
                pend_next     = 1'b0;
                case (cmd_reg)
                    tmte_pkg::CMD_PUT:
                    begin
                        if (char_reg == tmte_pkg::CH_NEWLINE)
                        begin
                            col_t = '0;
                            row_t = row_t + 1'b1;
                        end
                        else if (char_reg == tmte_pkg::CH_RETURN)
                        begin
                            col_t = '0;
                        end
                        else if (char_reg == tmte_pkg::CH_BACKSPACE)
                        begin
                            if (col_t != '0)
                            begin
                                col_t = col_t - 1'b1;
                            end
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = put_addr;
                            mem_wdata = tmte_pkg::make_cell(fg_reg, bg_reg, char_reg);
                            col_t     = col_t + 1'b1;
                        end
                        if (col_t == COL_LIM)
                        begin
                            col_t = '0;
                            row_t = row_t + 1'b1;
                        end
                        col_next = col_t[COL_W-1:0];
                        if (row_t == ROW_LIM)
                        begin
                            // past the bottom: scroll one line
                            row_next   = ROW_LAST;
                            src_next   = CNT_W'(COLUMNS);
                            state_next = tmte_pkg::ST_COPY;
                        end
                        else
                        begin
                            row_next   = row_t[ROW_W-1:0];
                            state_next = tmte_pkg::ST_DONE;
                        end
                    end

                    tmte_pkg::CMD_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        state_next = tmte_pkg::ST_FILL;
                    end

                    tmte_pkg::CMD_SCROLL:
                    begin
                        if (lines_reg == '0)
                        begin
                            state_next = tmte_pkg::ST_DONE;
                        end
                        else if (32'(lines_reg) >= ROWS)
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = tmte_pkg::ST_FILL;
                        end
                        else
                        begin
                            src_next   = CNT_W'(scroll_off);
                            row_next   = (32'(row_reg) > 32'(lines_reg))
                                         ? ROW_W'(32'(row_reg) - 32'(lines_reg)) : '0;
                            state_next = tmte_pkg::ST_COPY;
                        end
                    end

                    tmte_pkg::CMD_READ:
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ADDR_W'(cell_reg);
                        state_next = tmte_pkg::ST_RDWAIT;
                    end

                    default:
                    begin
                        state_next = tmte_pkg::ST_DONE;
                    end
                endcase
            end

            tmte_pkg::ST_RDWAIT:
            begin
                read_val_next = cell_in_range ? rd_data_reg : '0;
                state_next    = tmte_pkg::ST_DONE;
            end

            tmte_pkg::ST_COPY:
            begin
                // read runs one cell ahead of the write
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg;
                    dst_next  = dst_reg + 1'b1;
                end
                if (src_reg != CELL_END)
                begin
                    mem_re    = 1'b1;
                    src_next  = src_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = tmte_pkg::ST_FILL;
                    end
                end
            end

            tmte_pkg::ST_FILL:
            begin
                mem_we   = 1'b1;
                dst_next = dst_reg + 1'b1;
                if (dst_reg[ADDR_W-1:0] == LAST_ADDR)
                begin
                    state_next = tmte_pkg::ST_DONE;
                end
            end

            tmte_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_col_next   = tmte_pkg::COL_OUT_W'(col_reg);
                    rsp_row_next   = tmte_pkg::ROW_OUT_W'(row_reg);
                    rsp_cell_next  = read_val_reg;
                    state_next     = tmte_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tmte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmte_pkg::ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            dst_reg       <= '0;
            src_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            dst_reg       <= dst_next;
            src_reg       <= src_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= tmte_pkg::RESET_FG;
            bg_reg <= tmte_pkg::RESET_BG;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tmte_pkg::REG_FG: fg_reg <= cfg_data;
                tmte_pkg::REG_BG: bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        char_reg     <= char_next;
        lines_reg    <= lines_next;
        cell_reg     <= cell_next;
        read_val_reg <= read_val_next;
        rsp_col_reg  <= rsp_col_next;
        rsp_row_reg  <= rsp_row_next;
        rsp_cell_reg <= rsp_cell_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

// ===== sv/tmte_checker.sv =====
// ----------------------------------------------------------------------------
// tmte_checker: port-level checks for the text mode terminal engine
// Watches the command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module tmte_checker #(
    parameter int COLUMNS = tmte_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmte_pkg::ROWS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [tmte_pkg::COL_OUT_W-1:0]    cursor_col,
    input logic [tmte_pkg::ROW_OUT_W-1:0]    cursor_line,
    input logic [tmte_pkg::CELL_W-1:0]       read_cell
);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_col)
            && $stable(cursor_line) && $stable(read_cell))
        else $error("result word changed while stalled");

    // one command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command accepted while busy");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(cursor_col) < COLUMNS)
        else $error("cursor column out of range");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(cursor_line) < ROWS)
        else $error("cursor line out of range");

endmodule

bind text_mode_terminal_engine tmte_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .cursor_col  (rsp.cursor_col),
    .cursor_line (rsp.cursor_line),
    .read_cell   (rsp.read_cell)
);
